// ----- hw/rtl/rmsm_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the RMS sound level meter.
package rmsm_pkg;

  localparam int SUM_W = 40;
  localparam int CNT_W = 13;
  localparam int DB_W = 11;
  localparam int CLS_W = 2;
  localparam int ROOT_W = 21;
  localparam int MAX_BLOCK_DEF = 256;
  localparam logic [DB_W-1:0] DB_MAX = 11'd1920;
  localparam logic [DB_W-1:0] HIGH_RESET = 11'd1120;
  localparam logic [DB_W-1:0] MEDIUM_RESET = 11'd800;
  localparam logic [22:0] LOG_TO_DB16 = 23'd6313057;

  localparam logic [CLS_W-1:0] CLS_LOW = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_HIGH = 2'd2;

  localparam logic CFG_HIGH = 1'b0;
  localparam logic CFG_MEDIUM = 1'b1;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_LOG_INIT,
    OP_LOG_STEP
  } op_t;

  typedef struct packed {
    op_t op;
    logic mul_phase;
    logic scale;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic close;
  } status_t;

endpackage

// ----- hw/rtl/rmsm_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: accumulator, restoring divider, square root, log and dB scaling.
module rmsm_datapath #(
  parameter int MaxBlock = rmsm_pkg::MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rmsm_pkg::cmd_t              cmd,
  input  logic signed [15:0]          sample,
  input  logic                        block_end,
  input  logic [rmsm_pkg::DB_W-1:0]   high_level_db,
  input  logic [rmsm_pkg::DB_W-1:0]   medium_level_db,
  output rmsm_pkg::status_t           status,
  output logic [rmsm_pkg::DB_W-1:0]   level_db,
  output logic [rmsm_pkg::CLS_W-1:0]  loudness_class
);

  localparam int SW = rmsm_pkg::SUM_W;
  localparam int CW = rmsm_pkg::CNT_W;
  localparam int RW = rmsm_pkg::ROOT_W;
  localparam int DB_W_L = rmsm_pkg::DB_W;

  logic [SW-1:0] square_sum;
  logic [CW-1:0] sample_count;
  logic [SW-1:0] quo;
  logic [CW:0]   rem;
  logic [SW-1:0] sq_rem;
  logic [RW-1:0] root;
  logic [31:0]   x;
  logic [63:0]   prod;
  logic [15:0]   frac;
  logic [3:0]    expo;

  logic [15:0]   mag;
  logic [31:0]   sq;
  logic [SW:0]   sum_wide;
  logic [CW-1:0] cnt_inc;
  logic [CW:0]   rem_sh;
  logic [SW+1:0] sq_trial;
  logic [SW+1:0] sq_rem2;
  logic [RW:0]   root2;
  logic [61:0]   xs;
  logic [4:0]    top;
  logic [19:0]   lg;
  logic [42:0]   dbw;
  logic [DB_W_L-1:0] dbc;

  always_comb begin
    mag = sample[15] ? 16'(-sample) : 16'(sample);
    sq = 32'(mag) * 32'(mag);
    sum_wide = {1'b0, square_sum} + {9'd0, sq};
    cnt_inc = sample_count + 1'b1;
    rem_sh = {rem[CW-1:0], quo[SW-1]};
    // two sqrt digits from the top of the remaining mean
    sq_rem2 = {sq_rem, 2'b00};
    root2 = {root, 1'b0};
    sq_trial = {sq_rem2[SW+1:2], quo[SW-1:SW-2]} - {{(SW+1-RW-1){1'b0}}, root2, 1'b1};
    top = 5'd0;
    for (int i = 0; i < RW; i++) begin
      if (root[i]) top = 5'(i);
    end
    xs = 62'(x) * 62'(x) >> 30;
    lg = {expo, frac};
    dbw = 43'(prod[42:0]);
    dbc = (dbw[42:32] > rmsm_pkg::DB_MAX || dbw[42:32] == 11'h7ff) ?
          rmsm_pkg::DB_MAX : dbw[42:32];
  end

  assign status.close = block_end || (cnt_inc >= CW'(MaxBlock)) || (cnt_inc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      sample_count <= '0;
    end else begin
      case (cmd.op)
        rmsm_pkg::OP_ACC: begin
          square_sum <= sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
          sample_count <= cnt_inc;
        end
        rmsm_pkg::OP_DIV_INIT: begin
          quo <= square_sum;
          rem <= '0;
          if (sample_count == '0) sample_count <= CW'(1);
        end
        rmsm_pkg::OP_DIV_STEP: begin
          if (rem_sh >= {1'b0, sample_count}) begin
            rem <= rem_sh - {1'b0, sample_count};
            quo <= {quo[SW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[SW-2:0], 1'b0};
          end
        end
        rmsm_pkg::OP_SQRT_INIT: begin
          sq_rem <= '0;
          root <= '0;
        end
        rmsm_pkg::OP_SQRT_STEP: begin
          if (!sq_trial[SW+1]) begin
            sq_rem <= sq_trial[SW-1:0];
            root <= {root[RW-2:0], 1'b1};
          end else begin
            sq_rem <= {sq_rem2[SW-1:2], quo[SW-1:SW-2]};
            root <= {root[RW-2:0], 1'b0};
          end
          quo <= {quo[SW-3:0], 2'b00};
        end
        rmsm_pkg::OP_LOG_INIT: begin
          expo <= (root == '0) ? 4'd0 : 4'(top);
          x <= (root == '0) ? 32'h4000_0000 : 32'(64'(root) << (30 - top));
          frac <= '0;
        end
        rmsm_pkg::OP_LOG_STEP: begin
          if (cmd.scale) begin
            if (!cmd.mul_phase) prod <= 64'(lg) * 64'(rmsm_pkg::LOG_TO_DB16);
            else begin
              level_db <= dbc;
              if (dbc >= high_level_db) loudness_class <= rmsm_pkg::CLS_HIGH;
              else if (dbc >= medium_level_db) loudness_class <= rmsm_pkg::CLS_MEDIUM;
              else loudness_class <= rmsm_pkg::CLS_LOW;
            end
          end else if (!cmd.mul_phase) begin
            prod <= 64'(xs);
          end else begin
            if (prod[31]) begin
              x <= prod[32:1];
              frac <= {frac[14:0], 1'b1};
            end else begin
              x <= prod[31:0];
              frac <= {frac[14:0], 1'b0};
            end
          end
        end
        default: ;
      endcase
      if (cmd.clear) begin
        square_sum <= '0;
        sample_count <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/rmsm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences accumulate, divide, root, log and scale steps.
module rmsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rmsm_pkg::status_t status,
  output rmsm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SQRT, S_LOG, S_SCALE, S_HOLD
  } state_t;

  state_t state;
  logic [5:0] cnt;
  logic phase;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '{op: rmsm_pkg::OP_NONE, mul_phase: phase, scale: 1'b0, clear: 1'b0};
    case (state)
      S_IDLE: if (in_valid) cmd.op = rmsm_pkg::OP_ACC;
      S_DIV: cmd.op = (cnt == 6'd0 && !phase) ? rmsm_pkg::OP_DIV_INIT :
                                                rmsm_pkg::OP_DIV_STEP;
      S_SQRT: cmd.op = (cnt == 6'd0 && !phase) ? rmsm_pkg::OP_SQRT_INIT :
                                                 rmsm_pkg::OP_SQRT_STEP;
      S_LOG: cmd.op = (cnt == 6'd0 && !phase) ? rmsm_pkg::OP_LOG_INIT :
                                                rmsm_pkg::OP_LOG_STEP;
      S_SCALE: begin
        cmd.scale = 1'b1;
        // hold the final write until the previous result has gone
        if (!phase || !out_valid) begin
          cmd.op = rmsm_pkg::OP_LOG_STEP;
          cmd.clear = phase;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && status.close) begin
          state <= S_DIV;
          cnt <= '0;
          phase <= 1'b0;
        end
        S_DIV: begin
          // init cycle, then 40 quotient bits
          if (!phase) phase <= 1'b1;
          else if (cnt == 6'd39) begin
            state <= S_SQRT; cnt <= '0; phase <= 1'b0;
          end else cnt <= cnt + 1'b1;
        end
        S_SQRT: begin
          if (!phase) phase <= 1'b1;
          else if (cnt == 6'd19) begin
            state <= S_LOG; cnt <= '0; phase <= 1'b0;
          end else cnt <= cnt + 1'b1;
        end
        S_LOG: begin
          // init, then square and normalise per fraction bit
          if (cnt == 6'd0 && !phase) begin
            cnt <= 6'd1;
          end else if (!phase) phase <= 1'b1;
          else begin
            phase <= 1'b0;
            if (cnt == 6'd16) begin
              state <= S_SCALE; cnt <= '0;
            end else cnt <= cnt + 1'b1;
          end
        end
        S_SCALE: begin
          if (!phase) phase <= 1'b1;
          else if (!out_valid) begin
            phase <= 1'b0;
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("busy without stall");
  a_out_after_scale: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_SCALE) else $error("bad result start");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 6'd39) else $error("step count out of range");
`endif

endmodule

// ----- hw/rtl/block_rms_sound_level_meter.sv -----
`timescale 1ns / 1ps
// Top level of the block RMS sound level meter.
// Usage:
//   Input channel (in_valid/in_stall, sample, block_end) takes one signed
//   sample per transaction; its square is added to a saturating 40-bit sum.
//   A sample with block_end set, or the MAX_BLOCK-th sample, closes a block.
//   An ordinary sample is added without stalling. A closing sample starts
//   the sequencer: restoring division (one quotient bit a cycle), square
//   root (two radicand bits a cycle), log2 (init, then square and normalise
//   per fraction bit) and dB scaling, after which one result (level_db,
//   loudness_class) appears on the output channel (out_valid/out_stall) and
//   holds until taken. in_stall is high while the sequence runs; the next
//   sample can be taken in the same cycle as the result appears.
//   While the receiver stalls, the next block still accumulates; its sequence
//   holds in its last cycle until the earlier result is taken. Thresholds are
//   written through cfg_we/cfg_index/cfg_data; the user must do so only when
//   idle, the block does not enforce it. Synchronous reset clears sum, count
//   and pending result and loads the thresholds with 70 dB and 50 dB.
module block_rms_sound_level_meter #(
  parameter int MaxBlock = rmsm_pkg::MAX_BLOCK_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          sample,
  input  logic                        block_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rmsm_pkg::DB_W-1:0]   level_db,
  output logic [rmsm_pkg::CLS_W-1:0]  loudness_class,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rmsm_pkg::DB_W-1:0]   cfg_data
);

  logic [rmsm_pkg::DB_W-1:0] high_level_db;
  logic [rmsm_pkg::DB_W-1:0] medium_level_db;
  rmsm_pkg::cmd_t cmd;
  rmsm_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_level_db <= rmsm_pkg::HIGH_RESET;
      medium_level_db <= rmsm_pkg::MEDIUM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == rmsm_pkg::CFG_HIGH) high_level_db <= cfg_data;
      else medium_level_db <= cfg_data;
    end
  end

  rmsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  rmsm_datapath #(.MaxBlock(MaxBlock)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sample(sample), .block_end(block_end),
    .high_level_db(high_level_db), .medium_level_db(medium_level_db),
    .status(status), .level_db(level_db), .loudness_class(loudness_class)
  );

endmodule
